### rtl/core/geq_pkg.sv
// Shared types, constants and register codes of the gesture event qualifier.
package geq_pkg;

  // Field widths fixed by the interface.
  localparam int SAMPLE_W   = 16;
  localparam int SCORE_W    = 16;
  localparam int FRAMES_W   = 8;
  localparam int KIND_W     = 2;
  localparam int TAPS_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int MAG_W      = SAMPLE_W + 1;

  // Defaults for the top-level parameters.
  localparam int SUM_BITS_DEF  = 32;
  localparam int TAP_LIMIT_DEF = 3;

  // Result queue depth: room for two results of one frame plus slack.
  localparam int QUEUE_DEPTH = 4;

  // Register reset values.
  localparam logic [SCORE_W-1:0]  CIRCLE_THR_RST = 16'd26214;
  localparam logic [SCORE_W-1:0]  PUSH_THR_RST   = 16'd29491;
  localparam logic [FRAMES_W-1:0] TAP_GROUP_RST  = 8'd20;
  localparam logic [FRAMES_W-1:0] DEBOUNCE_RST   = 8'd4;
  localparam logic [FRAMES_W-1:0] SUPPRESS_RST   = 8'd24;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CIRCLE_THR = 3'd0,
    REG_PUSH_THR   = 3'd1,
    REG_TAP_GROUP  = 3'd2,
    REG_DEBOUNCE   = 3'd3,
    REG_SUPPRESS   = 3'd4
  } cfg_reg_t;

  // Result kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_TAP   = 2'd0,
    KIND_UP    = 2'd1,
    KIND_DOWN  = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic [SCORE_W-1:0]  circle_thr;
    logic [SCORE_W-1:0]  push_thr;
    logic [FRAMES_W-1:0] tap_group;
    logic [FRAMES_W-1:0] debounce;
    logic [FRAMES_W-1:0] suppress;
  } cfg_t;

  typedef struct packed {
    event_kind_t       kind;
    logic [TAPS_W-1:0] taps;
    logic              last;
  } result_t;

  // Up to two results produced by one frame end, in delivery order.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } result_pair_t;

endpackage

### rtl/core/geq_ifs.sv
// Request and result channel interfaces of the gesture event qualifier.
interface geq_sample_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [geq_pkg::SAMPLE_W-1:0]   sample;
  logic                                  frame_end;
  logic        [geq_pkg::SCORE_W-1:0]    circle_grade;
  logic        [geq_pkg::SCORE_W-1:0]    push_grade;

  modport source (output valid, sample, frame_end, circle_grade, push_grade, input ready);
  modport sink   (input valid, sample, frame_end, circle_grade, push_grade, output ready);
endinterface

interface geq_event_if;
  logic                          valid;
  logic                          ready;
  logic [geq_pkg::KIND_W-1:0]    event_kind;
  logic [geq_pkg::TAPS_W-1:0]    tap_total;
  logic                          last_event;

  modport source (output valid, event_kind, tap_total, last_event, input ready);
  modport sink   (input valid, event_kind, tap_total, last_event, output ready);
endinterface

### rtl/core/geq_frame_acc.sv
// Frame accumulator: saturating sum of absolute samples and change detection.
module geq_frame_acc #(
  parameter int SUM_BITS = geq_pkg::SUM_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                go,
  input  logic signed [geq_pkg::SAMPLE_W-1:0] sample,
  input  logic                                frame_end,
  output logic                                fell
);
  import geq_pkg::*;

  logic [SUM_BITS-1:0] abs_sum;
  logic [SUM_BITS-1:0] previous_sum;
  logic                have_previous;
  logic [MAG_W-1:0]    mag;
  logic [SUM_BITS:0]   sum_wide;
  logic [SUM_BITS-1:0] sum_sat;

  // Magnitude; the most negative sample gives 32768 in the wider word.
  assign mag = sample[SAMPLE_W-1] ? MAG_W'(~{1'b1, sample} + MAG_W'(1))
                                  : {1'b0, sample};

  // Saturating accumulate.
  assign sum_wide = {1'b0, abs_sum} + (SUM_BITS+1)'(mag);
  assign sum_sat  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

  // The frame energy fell against the previous frame; the first frame counts as up.
  assign fell = have_previous && (sum_sat < previous_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      abs_sum       <= '0;
      previous_sum  <= '0;
      have_previous <= 1'b0;
    end else if (go) begin
      if (frame_end) begin
        previous_sum  <= sum_sat;
        have_previous <= 1'b1;
        abs_sum       <= '0;
      end else begin
        abs_sum <= sum_sat;
      end
    end
  end

endmodule

### rtl/core/geq_timer_ctl.sv
// Frame timers, tap grouping and swipe qualification at each frame end.
module geq_timer_ctl #(
  parameter int TAP_LIMIT = geq_pkg::TAP_LIMIT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic                          frame_end,
  input  logic [geq_pkg::SCORE_W-1:0]   circle_grade,
  input  logic [geq_pkg::SCORE_W-1:0]   push_grade,
  input  logic                          fell,
  input  geq_pkg::cfg_t                 cfg,
  output geq_pkg::result_pair_t         pair
);
  import geq_pkg::*;

  localparam logic [TAPS_W-1:0] TAP_MAX = TAPS_W'(TAP_LIMIT);

  logic [TAPS_W-1:0]   tap_count, tap_count_next;
  logic [FRAMES_W-1:0] tap_timer, tap_timer_next;
  logic [FRAMES_W-1:0] debounce_timer, debounce_timer_next;
  logic [FRAMES_W-1:0] suppress_timer, suppress_timer_next;

  logic [FRAMES_W-1:0] tap_dec, deb_dec, sup_dec;
  logic [TAPS_W-1:0]   cnt_mid;
  logic                report, swipe, tap;
  result_t             tap_res, swipe_res;

  // Count the timers down and find an expired tap group.
  always_comb begin
    deb_dec = (debounce_timer != '0) ? debounce_timer - FRAMES_W'(1) : '0;
    sup_dec = (suppress_timer != '0) ? suppress_timer - FRAMES_W'(1) : '0;
    tap_dec = (tap_timer != '0) ? tap_timer - FRAMES_W'(1) : '0;
    report  = (tap_timer != '0) && (tap_dec == '0) && (tap_count != '0);
    cnt_mid = report ? '0 : tap_count;
    swipe   = (circle_grade >= cfg.circle_thr) && (sup_dec == '0);
    tap     = !swipe && (push_grade >= cfg.push_thr) && (deb_dec == '0) && (sup_dec == '0);
  end

  // Next state of the gesture timers.
  always_comb begin
    tap_count_next      = cnt_mid;
    tap_timer_next      = tap_dec;
    debounce_timer_next = deb_dec;
    suppress_timer_next = sup_dec;
    if (swipe) begin
      tap_count_next      = '0;
      tap_timer_next      = '0;
      debounce_timer_next = cfg.debounce;
      suppress_timer_next = cfg.suppress;
    end else if (tap) begin
      tap_count_next      = (cnt_mid < TAP_MAX) ? cnt_mid + TAPS_W'(1) : cnt_mid;
      tap_timer_next      = cfg.tap_group;
      debounce_timer_next = cfg.debounce;
    end
  end

  // Results of this frame: a tap report comes before a swipe.
  always_comb begin
    tap_res.kind   = KIND_TAP;
    tap_res.taps   = tap_count;
    tap_res.last   = !swipe;
    swipe_res.kind = fell ? KIND_DOWN : KIND_UP;
    swipe_res.taps = '0;
    swipe_res.last = 1'b1;
    pair.count     = 2'd0;
    pair.first     = tap_res;
    pair.second    = swipe_res;
    if (go && frame_end) begin
      if (report && swipe) begin
        pair.count = 2'd2;
      end else if (swipe) begin
        pair.count = 2'd1;
        pair.first = swipe_res;
      end else if (report) begin
        pair.count = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count      <= '0;
      tap_timer      <= '0;
      debounce_timer <= '0;
      suppress_timer <= '0;
    end else if (go && frame_end) begin
      tap_count      <= tap_count_next;
      tap_timer      <= tap_timer_next;
      debounce_timer <= debounce_timer_next;
      suppress_timer <= suppress_timer_next;
    end
  end

endmodule

### rtl/core/geq_result_queue.sv
// Small result queue: up to two results in a cycle, one out while ready.
module geq_result_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  geq_pkg::result_pair_t pair,
  output logic                  space_ok,
  geq_event_if.source           events
);
  import geq_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  result_t            mem [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               pop;
  result_t            head;

  // Room for a whole frame's results before a new request is processed.
  assign space_ok = (count <= CNT_W'(QUEUE_DEPTH - 2));
  assign pop      = events.valid && events.ready;
  assign head     = mem[rd_ptr];

  assign events.valid      = (count != '0);
  assign events.event_kind = head.kind;
  assign events.tap_total  = head.taps;
  assign events.last_event = head.last;

  // Storage writes.
  always_ff @(posedge clk) begin
    if (pair.count != 2'd0) begin
      mem[wr_ptr] <= pair.first;
    end
    if (pair.count == 2'd2) begin
      mem[wr_ptr + PTR_W'(1)] <= pair.second;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(pair.count);
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + CNT_W'(pair.count) - CNT_W'(pop);
    end
  end

endmodule

### rtl/core/gesture_event_qualifier.sv
// Top level of the gesture event qualifier: request register, config and datapath.
// The block takes one radar sample request per clock cycle while the queue has
// room and delivers one result per cycle while the result side is ready. A
// request is held in an input register, where the saturating absolute-value
// accumulate and, at frame end, the timer and gesture decisions are made in a
// single pass; results go into a four-entry queue. A frame end can queue two
// results (tap report, then swipe), so the request side pauses only when fewer
// than two queue entries are free, which can only follow a stall on the result
// side. Configuration writes take effect on the next cycle.
module gesture_event_qualifier #(
  parameter int SUM_BITS  = geq_pkg::SUM_BITS_DEF,
  parameter int TAP_LIMIT = geq_pkg::TAP_LIMIT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_wr_en,
  input  logic [geq_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [geq_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
  geq_sample_if.sink                       samples,
  geq_event_if.source                      events
);
  import geq_pkg::*;

  cfg_t                        cfg;
  logic                        stg_valid;
  logic signed [SAMPLE_W-1:0]  stg_sample;
  logic                        stg_frame_end;
  logic [SCORE_W-1:0]          stg_circle;
  logic [SCORE_W-1:0]          stg_push;
  logic                        go;
  logic                        space_ok;
  logic                        fell;
  result_pair_t                pair;

  // Configuration registers; unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.circle_thr <= CIRCLE_THR_RST;
      cfg.push_thr   <= PUSH_THR_RST;
      cfg.tap_group  <= TAP_GROUP_RST;
      cfg.debounce   <= DEBOUNCE_RST;
      cfg.suppress   <= SUPPRESS_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CIRCLE_THR: cfg.circle_thr <= cfg_wr_data;
        REG_PUSH_THR:   cfg.push_thr   <= cfg_wr_data;
        REG_TAP_GROUP:  cfg.tap_group  <= cfg_wr_data[FRAMES_W-1:0];
        REG_DEBOUNCE:   cfg.debounce   <= cfg_wr_data[FRAMES_W-1:0];
        REG_SUPPRESS:   cfg.suppress   <= cfg_wr_data[FRAMES_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register: processed when the queue has room for a frame's results.
  assign go            = stg_valid && space_ok;
  assign samples.ready = !stg_valid || go;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (samples.ready) begin
      stg_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      stg_sample    <= samples.sample;
      stg_frame_end <= samples.frame_end;
      stg_circle    <= samples.circle_grade;
      stg_push      <= samples.push_grade;
    end
  end

  geq_frame_acc #(
    .SUM_BITS (SUM_BITS)
  ) u_frame_acc (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .sample    (stg_sample),
    .frame_end (stg_frame_end),
    .fell      (fell)
  );

  geq_timer_ctl #(
    .TAP_LIMIT (TAP_LIMIT)
  ) u_timer_ctl (
    .clk          (clk),
    .rst          (rst),
    .go           (go),
    .frame_end    (stg_frame_end),
    .circle_grade (stg_circle),
    .push_grade   (stg_push),
    .fell         (fell),
    .cfg          (cfg),
    .pair         (pair)
  );

  geq_result_queue u_result_queue (
    .clk      (clk),
    .rst      (rst),
    .pair     (pair),
    .space_ok (space_ok),
    .events   (events)
  );

endmodule

### bench/tb_gesture_event_qualifier.sv
// Self-checking testbench of the gesture event qualifier: directed table, then random frames.
module tb_gesture_event_qualifier;
  timeunit 1ns;
  timeprecision 1ps;

  import geq_pkg::*;

  localparam int SUM_W       = SUM_BITS_DEF;
  localparam int TAIL_CYCLES = 8;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       frame_end;
    logic [SCORE_W-1:0]         circle_grade;
    logic [SCORE_W-1:0]         push_grade;
  } req_t;

  typedef enum {ROW_ITEM, ROW_SETTINGS} row_kind_t;

  // One row of the directed table. typed_n < 0 leaves the row to the predictor.
  typedef struct {
    row_kind_t kind;
    cfg_t      settings;
    req_t      req;
    int        typed_n;
    result_t   typed_a;
    result_t   typed_b;
  } row_t;

  localparam result_t NO_EVENT = '0;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wr_data;

  geq_sample_if samples ();
  geq_event_if  events ();

  gesture_event_qualifier dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .samples     (samples),
    .events      (events)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state and its copy of the registers.
  cfg_t                 shadow_cfg;
  logic [SUM_W-1:0]     sum_now;
  logic [SUM_W-1:0]     sum_before;
  logic                 have_before;
  logic [TAPS_W-1:0]    taps_held;
  logic [FRAMES_W-1:0]  group_left;
  logic [FRAMES_W-1:0]  debounce_left;
  logic [FRAMES_W-1:0]  quiet_left;

  result_t forecast[$];
  result_t awaited_events[$];
  row_t    plan[$];
  result_t want;
  int      mismatches = 0;
  int      stall_left = 0;
  int      cycle_count = 0;
  bit      pace_on = 1'b0;
  bit      stalls_on = 1'b0;

  function automatic result_t make_event(event_kind_t kind, logic [TAPS_W-1:0] taps,
                                         logic last);
    result_t ev;
    ev.kind = kind;
    ev.taps = taps;
    ev.last = last;
    return ev;
  endfunction

  function automatic cfg_t make_settings(logic [SCORE_W-1:0] circle, logic [SCORE_W-1:0] push,
                                         logic [FRAMES_W-1:0] group,
                                         logic [FRAMES_W-1:0] debounce,
                                         logic [FRAMES_W-1:0] suppress);
    cfg_t c;
    c.circle_thr = circle;
    c.push_thr   = push;
    c.tap_group  = group;
    c.debounce   = debounce;
    c.suppress   = suppress;
    return c;
  endfunction

  // Accumulate one sample and, at frame end, qualify the gesture; results go to forecast.
  function automatic void qualify_request(req_t r);
    logic [MAG_W-1:0]  mag;
    logic [SUM_W:0]    wide;
    logic              fell;
    logic              report;
    logic [TAPS_W-1:0] reported;
    forecast.delete();
    mag  = r.sample[SAMPLE_W-1] ? (17'h10000 - {1'b0, r.sample}) : {1'b0, r.sample};
    wide = {1'b0, sum_now} + {{(SUM_W + 1 - MAG_W){1'b0}}, mag};
    sum_now = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
    if (!r.frame_end) return;

    fell        = have_before && (sum_now < sum_before);
    sum_before  = sum_now;
    have_before = 1'b1;
    sum_now     = '0;

    // Frame timers tick once per frame; an expiring tap group is reported.
    report   = 1'b0;
    reported = '0;
    if (debounce_left != 0) debounce_left--;
    if (quiet_left != 0) quiet_left--;
    if (group_left != 0) begin
      group_left--;
      if (group_left == 0 && taps_held != 0) begin
        report    = 1'b1;
        reported  = taps_held;
        taps_held = '0;
      end
    end

    // A swipe wins over a tap and restarts the hold-off timers.
    if (r.circle_grade >= shadow_cfg.circle_thr && quiet_left == 0) begin
      if (report) forecast.push_back(make_event(KIND_TAP, reported, 1'b0));
      forecast.push_back(make_event(fell ? KIND_DOWN : KIND_UP, '0, 1'b1));
      quiet_left    = shadow_cfg.suppress;
      debounce_left = shadow_cfg.debounce;
      taps_held     = '0;
      group_left    = '0;
      return;
    end

    if (r.push_grade >= shadow_cfg.push_thr && debounce_left == 0 && quiet_left == 0) begin
      if (taps_held < TAP_LIMIT_DEF) taps_held++;
      group_left    = shadow_cfg.tap_group;
      debounce_left = shadow_cfg.debounce;
    end
    if (report) forecast.push_back(make_event(KIND_TAP, reported, 1'b1));
  endfunction

  function automatic int pick_gap();
    if ($urandom_range(9) == 0) return int'($urandom_range(10, 40));
    return int'($urandom_range(1, 3));
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    unique case ($urandom_range(7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Scores cluster on the threshold and the extremes so both sides of each compare occur.
  function automatic logic [SCORE_W-1:0] pick_score(logic [SCORE_W-1:0] thr);
    unique case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return thr;
      3:       return thr - 16'd1;
      default: return SCORE_W'($urandom);
    endcase
  endfunction

  function automatic void plan_item(logic [SAMPLE_W-1:0] s, logic fe, logic [SCORE_W-1:0] c,
                                    logic [SCORE_W-1:0] p, int n, result_t a, result_t b);
    row_t row;
    row.kind               = ROW_ITEM;
    row.settings           = '0;
    row.req.sample         = s;
    row.req.frame_end      = fe;
    row.req.circle_grade   = c;
    row.req.push_grade     = p;
    row.typed_n            = n;
    row.typed_a            = a;
    row.typed_b            = b;
    plan.push_back(row);
  endfunction

  function automatic void plan_settings(cfg_t c);
    row_t row;
    row.kind             = ROW_SETTINGS;
    row.settings         = c;
    row.req.sample       = '0;
    row.req.frame_end    = 1'b0;
    row.req.circle_grade = '0;
    row.req.push_grade   = '0;
    row.typed_n          = 0;
    row.typed_a          = NO_EVENT;
    row.typed_b          = NO_EVENT;
    plan.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [1:0] want_v, logic [1:0] got_v);
    if (got_v !== want_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want_v, got_v);
    end
  endfunction

  // Write every register, one per cycle; only called while the block is idle.
  task automatic apply_settings(cfg_t c);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= REG_CIRCLE_THR;
    cfg_wr_data <= c.circle_thr;
    @(posedge clk);
    cfg_index   <= REG_PUSH_THR;
    cfg_wr_data <= c.push_thr;
    @(posedge clk);
    cfg_index   <= REG_TAP_GROUP;
    cfg_wr_data <= {8'd0, c.tap_group};
    @(posedge clk);
    cfg_index   <= REG_DEBOUNCE;
    cfg_wr_data <= {8'd0, c.debounce};
    @(posedge clk);
    cfg_index   <= REG_SUPPRESS;
    cfg_wr_data <= {8'd0, c.suppress};
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    shadow_cfg  = c;
  endtask

  // Hold requests back until every awaited result has arrived and the pipeline is empty.
  task automatic settle();
    samples.valid <= 1'b0;
    while (awaited_events.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Offer one request, wait for its acceptance and record the results it should cause.
  task automatic send_request(req_t r, int typed_n, result_t a, result_t b);
    int gap;
    samples.valid        <= 1'b1;
    samples.sample       <= r.sample;
    samples.frame_end    <= r.frame_end;
    samples.circle_grade <= r.circle_grade;
    samples.push_grade   <= r.push_grade;
    @(posedge clk);
    while (!samples.ready) @(posedge clk);
    qualify_request(r);
    if (typed_n < 0) begin
      foreach (forecast[i]) awaited_events.push_back(forecast[i]);
    end else begin
      if (typed_n > 0) awaited_events.push_back(a);
      if (typed_n > 1) awaited_events.push_back(b);
    end
    if (pace_on && $urandom_range(3) == 0) begin
      gap = pick_gap();
      samples.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random frames under one register setting, mostly short frames with random content.
  task automatic run_phase(cfg_t c, int items, bit sender_idle, bit receiver_idle);
    req_t r;
    int   sent;
    int   frame_len;
    settle();
    apply_settings(c);
    pace_on   = sender_idle;
    stalls_on = receiver_idle;
    sent      = 0;
    while (sent < items) begin
      frame_len = ($urandom_range(3) == 0) ? int'($urandom_range(2, 12))
                                           : int'($urandom_range(1, 3));
      for (int k = 0; k < frame_len; k++) begin
        r.sample       = pick_sample();
        r.frame_end    = (k == frame_len - 1);
        r.circle_grade = pick_score(c.circle_thr);
        r.push_grade   = pick_score(c.push_thr);
        send_request(r, -1, NO_EVENT, NO_EVENT);
        sent++;
      end
      if ($urandom_range(40) == 0) settle();
    end
  endtask

  // Result side: check each accepted result and stall at random.
  always @(posedge clk) begin
    if (rst) begin
      events.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (events.valid && events.ready) begin
        if (awaited_events.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, kind %0d taps %0d last %0d", $time,
                   events.event_kind, events.tap_total, events.last_event);
        end else begin
          want = awaited_events.pop_front();
          check_field("event_kind", want.kind, events.event_kind);
          check_field("tap_total", want.taps, events.tap_total);
          check_field("last_event", {1'b0, want.last}, {1'b0, events.last_event});
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        events.ready <= 1'b0;
      end else if (stalls_on && $urandom_range(7) == 0) begin
        stall_left = pick_gap() - 1;
        events.ready <= 1'b0;
      end else begin
        events.ready <= 1'b1;
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    cfg_t c;

    rst                  <= 1'b1;
    cfg_wr_en            <= 1'b0;
    cfg_index            <= REG_CIRCLE_THR;
    cfg_wr_data          <= '0;
    samples.valid        <= 1'b0;
    samples.sample       <= '0;
    samples.frame_end    <= 1'b0;
    samples.circle_grade <= '0;
    samples.push_grade   <= '0;

    shadow_cfg    = make_settings(CIRCLE_THR_RST, PUSH_THR_RST, TAP_GROUP_RST, DEBOUNCE_RST,
                                  SUPPRESS_RST);
    sum_now       = '0;
    sum_before    = '0;
    have_before   = 1'b0;
    taps_held     = '0;
    group_left    = '0;
    debounce_left = '0;
    quiet_left    = '0;

    // Directed table. Reset values first: scores one below their thresholds give nothing.
    plan_item(16'h7FFF, 1'b0, 16'h0000, 16'h0000, 0, NO_EVENT, NO_EVENT);
    plan_item(16'h8000, 1'b1, 16'd26213, 16'd29490, 0, NO_EVENT, NO_EVENT);
    // Shortest tap group: a tap is reported on the very next frame.
    plan_settings(make_settings(16'hFFFF, 16'h0000, 8'd1, 8'd0, 8'd0));
    plan_item(16'd100, 1'b1, 16'hFFFE, 16'h0000, 0, NO_EVENT, NO_EVENT);
    plan_item(16'd0, 1'b1, 16'h0000, 16'h0000, 1,
              make_event(KIND_TAP, 2'd1, 1'b1), NO_EVENT);
    // Tap report and swipe from the same frame, report first.
    plan_item(16'd50, 1'b1, 16'hFFFF, 16'h0000, 2,
              make_event(KIND_TAP, 2'd1, 1'b0), make_event(KIND_UP, 2'd0, 1'b1));
    plan_item(16'hFFFF, 1'b1, 16'hFFFF, 16'h0000, 1,
              make_event(KIND_DOWN, 2'd0, 1'b1), NO_EVENT);
    plan_item(16'h8000, 1'b1, 16'hFFFF, 16'hFFFF, 1,
              make_event(KIND_UP, 2'd0, 1'b1), NO_EVENT);
    // Zero tap group: taps pile up to the limit and are never reported.
    plan_settings(make_settings(16'hFFFF, 16'hFFFF, 8'd0, 8'd0, 8'd0));
    repeat (4) plan_item(16'd0, 1'b1, 16'h0000, 16'hFFFF, -1, NO_EVENT, NO_EVENT);
    plan_item(16'd0, 1'b1, 16'hFFFF, 16'h0000, 1,
              make_event(KIND_UP, 2'd0, 1'b1), NO_EVENT);
    // Zero thresholds and the longest debounce: every frame is a swipe.
    plan_settings(make_settings(16'h0000, 16'h0000, 8'd255, 8'd255, 8'd0));
    plan_item(16'h7FFF, 1'b1, 16'h0000, 16'h0000, 1,
              make_event(KIND_UP, 2'd0, 1'b1), NO_EVENT);
    plan_item(16'd0, 1'b1, 16'h0000, 16'h0000, 1,
              make_event(KIND_DOWN, 2'd0, 1'b1), NO_EVENT);
    plan_item(16'h7FFF, 1'b0, 16'hFFFF, 16'hFFFF, -1, NO_EVENT, NO_EVENT);
    plan_item(16'h1234, 1'b1, 16'h0000, 16'h0000, -1, NO_EVENT, NO_EVENT);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SETTINGS) begin
        settle();
        apply_settings(plan[i].settings);
      end else begin
        send_request(plan[i].req, plan[i].typed_n, plan[i].typed_a, plan[i].typed_b);
      end
    end

    // Random phases, idling on each side switched per phase; the longest timers come last.
    for (int p = 0; p < 7; p++) begin
      unique case (p)
        0: c = make_settings(CIRCLE_THR_RST, PUSH_THR_RST, TAP_GROUP_RST, DEBOUNCE_RST,
                             SUPPRESS_RST);
        3: c = make_settings(16'h0000, 16'h0000, 8'd0, 8'd0, 8'd0);
        6: c = make_settings(16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255);
        default: c = make_settings(SCORE_W'($urandom), SCORE_W'($urandom),
                                   FRAMES_W'($urandom_range(1, 4)),
                                   FRAMES_W'($urandom_range(0, 3)),
                                   FRAMES_W'($urandom_range(0, 5)));
      endcase
      run_phase(c, (p == 0) ? 250 : ((p == 3 || p == 6) ? 100 : 200),
                (p % 4 == 0) || (p % 4 == 1), (p % 4 == 0) || (p % 4 == 2));
    end

    settle();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
